@@ src/mep_pkg.sv @@
// Shared constants and types of the escape-time pixel unit.
// No dependencies; every other file of the unit refers to this package by scoped names.
`default_nettype none

package mep_pkg;

   // Multiplier digit size in bits: one digit of the second operand per cycle.
   localparam int MUL_DIGIT = 16;

   // Result field widths that do not follow any parameter.
   localparam int ITER_WIDTH = 16;
   localparam int GRAY_WIDTH = 8;

   // Depth of the queue between the front and the iteration engine.
   localparam int QUEUE_DEPTH = 4;

   // Iteration limit after reset.
   localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd5000;

   // Configuration register indexes.
   localparam int REG_INDEX_WIDTH = 3;
   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_X_MIN    = 3'd0,
      REG_Y_MIN    = 3'd1,
      REG_X_STEP   = 3'd2,
      REG_Y_STEP   = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   // Fill status of the point queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/mep_mul.sv @@
// Digit-serial unsigned multiplier: one MUL_DIGIT-bit digit of operand b per cycle.
// Depends on mep_pkg for the digit size.
`default_nettype none

module mep_mul #(
   parameter int OP_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OP_WIDTH-1:0]     a,
   input  logic [OP_WIDTH-1:0]     b,
   output logic                    done,
   output logic [2*OP_WIDTH-1:0]   product
);

   localparam int DIG        = mep_pkg::MUL_DIGIT;
   localparam int NUM_DIGITS = (OP_WIDTH + DIG - 1) / DIG;
   localparam int B_WIDTH    = NUM_DIGITS * DIG;
   localparam int ACC_WIDTH  = OP_WIDTH + B_WIDTH;
   localparam int PART_WIDTH = OP_WIDTH + DIG;
   localparam int CNT_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic [OP_WIDTH-1:0]   a_ff, a_in;
   logic [B_WIDTH-1:0]    b_ff, b_in;
   logic [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [PART_WIDTH-1:0] partial;
   logic                  last_step;

   // One partial product per cycle; the accumulator shifts right by a digit.
   assign partial   = PART_WIDTH'(a_ff) * PART_WIDTH'(b_ff[DIG-1:0]);
   assign last_step = busy_ff && (cnt_ff == CNT_WIDTH'(NUM_DIGITS - 1));

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff && !last_step;
      done_in = last_step;
      if (start) begin
         a_in    = a;
         b_in    = B_WIDTH'(b);
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         b_in   = b_ff >> DIG;
         acc_in = (acc_ff >> DIG) + (ACC_WIDTH'(partial) << (B_WIDTH - DIG));
         cnt_in = cnt_ff + CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[2*OP_WIDTH-1:0];

endmodule

`default_nettype wire

@@ src/mep_front.sv @@
// Front part: accepts pixel beats and maps each position to a saturated point c.
// Depends on mep_pkg for the queue status type.
`default_nettype none

module mep_front #(
   parameter int COORD_WIDTH = 32,
   parameter int POS_WIDTH   = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [POS_WIDTH-1:0]         in_col,
   input  logic [POS_WIDTH-1:0]         in_row,
   input  logic [COORD_WIDTH-1:0]       x_min,
   input  logic [COORD_WIDTH-1:0]       y_min,
   input  logic [COORD_WIDTH-2:0]       x_step,
   input  logic [COORD_WIDTH-2:0]       y_step,
   input  mep_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output logic [COORD_WIDTH-1:0]       c_re,
   output logic [COORD_WIDTH-1:0]       c_im,
   output logic [POS_WIDTH-1:0]         out_col,
   output logic [POS_WIDTH-1:0]         out_row
);

   localparam int W          = COORD_WIDTH;
   localparam int PROD_WIDTH = POS_WIDTH + W - 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int HI_WIDTH   = SUM_WIDTH - W + 1;
   localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   logic                  s1_valid_ff, s1_valid_in;
   logic [PROD_WIDTH-1:0] prod_re_ff, prod_im_ff;
   logic [POS_WIDTH-1:0]  s1_col_ff, s1_row_ff;
   logic                  s2_valid_ff, s2_valid_in;
   logic [W-1:0]          c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [POS_WIDTH-1:0]  s2_col_ff, s2_row_ff;
   logic                  s1_load, s2_load, s2_free;
   logic [SUM_WIDTH-1:0]  sum_re, sum_im;
   logic [HI_WIDTH-1:0]   hi_re, hi_im;

   // Stage handshake: each stage moves when the one after it has room.
   assign q_push      = s2_valid_ff && !q_status.full;
   assign s2_free     = !s2_valid_ff || q_push;
   assign in_ready    = !s1_valid_ff || s2_free;
   assign s1_load     = in_valid && in_ready;
   assign s2_load     = s1_valid_ff && s2_free;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s2_load || (s2_valid_ff && !q_push);

   // Edge plus offset; the step is unsigned, the edge signed.
   assign sum_re = SUM_WIDTH'(prod_re_ff) + {{(SUM_WIDTH - W){x_min[W-1]}}, x_min};
   assign sum_im = SUM_WIDTH'(prod_im_ff) + {{(SUM_WIDTH - W){y_min[W-1]}}, y_min};
   assign hi_re  = sum_re[SUM_WIDTH-1:W-1];
   assign hi_im  = sum_im[SUM_WIDTH-1:W-1];

   // Saturate to the coordinate range when the upper bits are not a sign run.
   always_comb begin
      if ((&hi_re) || !(|hi_re)) begin
         c_re_in = sum_re[W-1:0];
      end else begin
         c_re_in = sum_re[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
      if ((&hi_im) || !(|hi_im)) begin
         c_im_in = sum_im[W-1:0];
      end else begin
         c_im_in = sum_im[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_load) begin
         prod_re_ff <= PROD_WIDTH'(in_col) * PROD_WIDTH'(x_step);
         prod_im_ff <= PROD_WIDTH'(in_row) * PROD_WIDTH'(y_step);
         s1_col_ff  <= in_col;
         s1_row_ff  <= in_row;
      end
      if (s2_load) begin
         c_re_ff   <= c_re_in;
         c_im_ff   <= c_im_in;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   assign c_re    = c_re_ff;
   assign c_im    = c_im_ff;
   assign out_col = s2_col_ff;
   assign out_row = s2_row_ff;

endmodule

`default_nettype wire

@@ src/mep_queue.sv @@
// Short register queue that carries mapped points from the front to the engine.
// Depends on mep_pkg for depth and status type.
`default_nettype none

module mep_queue #(
   parameter int DATA_WIDTH = 88
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DATA_WIDTH-1:0]     push_data,
   input  logic                      pop,
   output logic [DATA_WIDTH-1:0]     pop_data,
   output mep_pkg::queue_status_type status
);

   localparam int DEPTH     = mep_pkg::QUEUE_DEPTH;
   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   // Pointers wrap over the slots; the count tells full from empty.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_WIDTH'(1);
         2'b01:   count_in = count_ff - CNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ src/mep_back.sv @@
// Back part: iterates z = z*z + c for one point at a time, then derives the gray level.
// Depends on mep_pkg and on mep_mul for the two squares and the cross product.
`default_nettype none

module mep_back #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_WIDTH  = 28,
   parameter int POS_WIDTH   = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mep_pkg::queue_status_type          q_status,
   input  logic [COORD_WIDTH-1:0]             q_c_re,
   input  logic [COORD_WIDTH-1:0]             q_c_im,
   input  logic [POS_WIDTH-1:0]               q_col,
   input  logic [POS_WIDTH-1:0]               q_row,
   output logic                               q_pop,
   input  logic [mep_pkg::ITER_WIDTH-1:0]     max_iter,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [POS_WIDTH-1:0]               rsp_col,
   output logic [POS_WIDTH-1:0]               rsp_row,
   output logic [mep_pkg::ITER_WIDTH-1:0]     rsp_iterations,
   output logic [mep_pkg::GRAY_WIDTH-1:0]     rsp_gray
);

   localparam int W   = COORD_WIDTH;
   localparam int PW  = 2 * W;
   localparam int SW  = PW + 2;
   localparam int HW  = SW - W + 1;
   localparam int IW  = mep_pkg::ITER_WIDTH;
   localparam int GW  = mep_pkg::GRAY_WIDTH;
   localparam int DW  = IW + GW;
   localparam int DCW = $clog2(GW);
   localparam logic [PW:0]  ESC_LIMIT = {{PW{1'b0}}, 1'b1} << (2 * FRAC_WIDTH + 2);
   localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_TEST = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ESC  = 7'b0001000,
      ST_ADD  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [W-1:0]         c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic [W-1:0]         x_ff, x_in, y_ff, y_in;
   logic [POS_WIDTH-1:0] col_ff, col_in, row_ff, row_in;
   logic [IW-1:0]        iter_ff, iter_in;
   logic                 xy_neg_ff, xy_neg_in;
   logic                 esc_ff, esc_in;
   logic [PW:0]          re_sh_ff, re_sh_in, im_sh_ff, im_sh_in;
   logic [DW-1:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [GW-1:0]        quo_ff, quo_in;
   logic [DCW-1:0]       div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_WIDTH-1:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [IW-1:0]        rsp_iter_ff, rsp_iter_in;
   logic [GW-1:0]        rsp_gray_ff, rsp_gray_in;

   logic                 mul_start, div_load;
   logic                 done_xx, done_yy, done_xy;
   logic [PW-1:0]        xx, yy, xy;
   logic [W-1:0]         x_mag, y_mag;
   logic [PW:0]          sq_sum;
   logic signed [PW:0]   re_diff, re_sh, xy_signed, im_sh;
   logic [SW-1:0]        re_sum, im_sum;
   logic [HW-1:0]        hi_re, hi_im;
   logic [W-1:0]         x_sat, y_sat;
   logic                 div_ge;

   // Magnitudes feed the unsigned multipliers; the cross sign is kept aside.
   assign x_mag = x_ff[W-1] ? (~x_ff + W'(1)) : x_ff;
   assign y_mag = y_ff[W-1] ? (~y_ff + W'(1)) : y_ff;

   mep_mul #(.OP_WIDTH(W)) u_mul_xx (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (x_mag),
      .b       (x_mag),
      .done    (done_xx),
      .product (xx)
   );

   mep_mul #(.OP_WIDTH(W)) u_mul_yy (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (y_mag),
      .b       (y_mag),
      .done    (done_yy),
      .product (yy)
   );

   mep_mul #(.OP_WIDTH(W)) u_mul_xy (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (x_mag),
      .b       (y_mag),
      .done    (done_xy),
      .product (xy)
   );

   // Escape test and scaled update terms, from the finished products.
   assign sq_sum    = {1'b0, xx} + {1'b0, yy};
   assign re_diff   = $signed({1'b0, xx}) - $signed({1'b0, yy});
   assign re_sh     = re_diff >>> FRAC_WIDTH;
   assign xy_signed = xy_neg_ff ? -$signed({1'b0, xy}) : $signed({1'b0, xy});
   assign im_sh     = xy_signed >>> (FRAC_WIDTH - 1);

   // Add c back in and saturate to the coordinate range.
   assign re_sum = {re_sh_ff[PW], re_sh_ff} + {{(SW - W){c_re_ff[W-1]}}, c_re_ff};
   assign im_sum = {im_sh_ff[PW], im_sh_ff} + {{(SW - W){c_im_ff[W-1]}}, c_im_ff};
   assign hi_re  = re_sum[SW-1:W-1];
   assign hi_im  = im_sum[SW-1:W-1];

   always_comb begin
      if ((&hi_re) || !(|hi_re)) begin
         x_sat = re_sum[W-1:0];
      end else begin
         x_sat = re_sum[SW-1] ? COORD_MIN : COORD_MAX;
      end
      if ((&hi_im) || !(|hi_im)) begin
         y_sat = im_sum[W-1:0];
      end else begin
         y_sat = im_sum[SW-1] ? COORD_MIN : COORD_MAX;
      end
   end

   // One restoring division step per cycle: the quotient never exceeds 255.
   assign div_ge = (rem_ff >= dsr_ff);

   // Sequencer of the iteration engine and the output register.
   always_comb begin
      state_in     = state_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      iter_in      = iter_ff;
      xy_neg_in    = xy_neg_ff;
      esc_in       = esc_ff;
      re_sh_in     = re_sh_ff;
      im_sh_in     = im_sh_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_gray_in  = rsp_gray_ff;
      q_pop        = 1'b0;
      mul_start    = 1'b0;
      div_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               c_re_in  = q_c_re;
               c_im_in  = q_c_im;
               x_in     = q_c_re;
               y_in     = q_c_im;
               col_in   = q_col;
               row_in   = q_row;
               iter_in  = '0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (iter_ff < max_iter) begin
               mul_start = 1'b1;
               xy_neg_in = x_ff[W-1] ^ y_ff[W-1];
               state_in  = ST_MUL;
            end else begin
               div_load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            if (done_xx && done_yy && done_xy) begin
               state_in = ST_ESC;
            end
         end
         ST_ESC: begin
            esc_in   = (sq_sum > ESC_LIMIT);
            re_sh_in = re_sh;
            im_sh_in = im_sh;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (esc_ff) begin
               div_load = 1'b1;
               state_in = ST_DIV;
            end else begin
               x_in     = x_sat;
               y_in     = y_sat;
               iter_in  = iter_ff + IW'(1);
               state_in = ST_TEST;
            end
         end
         ST_DIV: begin
            rem_in     = div_ge ? (rem_ff - dsr_ff) : rem_ff;
            quo_in     = {quo_ff[GW-2:0], div_ge};
            dsr_in     = dsr_ff >> 1;
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(GW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               rsp_iter_in  = iter_ff;
               rsp_gray_in  = (max_iter == '0) ? '0 : quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Dividend is 255 * iterations, divisor starts at max_iter * 128.
      if (div_load) begin
         rem_in     = {iter_ff, {GW{1'b0}}} - DW'(iter_ff);
         dsr_in     = DW'(max_iter) << (GW - 1);
         quo_in     = '0;
         div_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      iter_ff     <= iter_in;
      xy_neg_ff   <= xy_neg_in;
      esc_ff      <= esc_in;
      re_sh_ff    <= re_sh_in;
      im_sh_ff    <= im_sh_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_gray_ff <= rsp_gray_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_col        = rsp_col_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_gray       = rsp_gray_ff;

endmodule

`default_nettype wire

@@ src/mandelbrot_escape_pixel_unit.sv @@
// One pixel iterates at a time, each iteration waiting on the digit-serial multipliers;
// up to four mapped points wait in the queue meanwhile.
// Synchronous reset clears control state and loads the register defaults.
// Top level of the escape-time pixel unit; depends on mep_pkg, mep_front, mep_queue, mep_back.
`default_nettype none

module mandelbrot_escape_pixel_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_WIDTH  = 28,
   parameter int POS_WIDTH   = 12,
   localparam int CSR_DATA_WIDTH = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_SHIFT     = (COORD_WIDTH > 32) ? 3 : 2,
   localparam int CSR_ADDR_WIDTH = ADDR_SHIFT + mep_pkg::REG_INDEX_WIDTH,
   localparam int REQ_DATA_WIDTH = ((2 * POS_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH =
      ((2 * POS_WIDTH + mep_pkg::ITER_WIDTH + mep_pkg::GRAY_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // Pixel beats: col, then row, from bit 0 up.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // Result beats: out_col, out_row, iterations, gray, from bit 0 up.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // Register port.
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready
);

   localparam int W  = COORD_WIDTH;
   localparam int IW = mep_pkg::ITER_WIDTH;
   localparam int GW = mep_pkg::GRAY_WIDTH;
   localparam int QW = 2 * W + 2 * POS_WIDTH;
   localparam logic [W-1:0] EDGE_RESET = ~(W'(1) << (FRAC_WIDTH + 1)) + W'(1);
   localparam logic [W-2:0] STEP_RESET = (W-1)'(1) << (FRAC_WIDTH - 7);

   logic [W-1:0]  x_min_ff, x_min_in, y_min_ff, y_min_in;
   logic [W-2:0]  x_step_ff, x_step_in, y_step_ff, y_step_in;
   logic [IW-1:0] max_iter_ff, max_iter_in;

   logic                          csr_write;
   mep_pkg::reg_index_type        csr_index;
   mep_pkg::queue_status_type     q_status;
   logic                          q_push, q_pop;
   logic [W-1:0]                  f_c_re, f_c_im;
   logic [POS_WIDTH-1:0]          f_col, f_row;
   logic [QW-1:0]                 q_wdata, q_rdata;
   logic [POS_WIDTH-1:0]          rsp_col, rsp_row;
   logic [IW-1:0]                 rsp_iterations;
   logic [GW-1:0]                 rsp_gray;

   // Register port: writes complete in the access cycle, no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = mep_pkg::reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:ADDR_SHIFT]);

   always_comb begin
      x_min_in    = x_min_ff;
      y_min_in    = y_min_ff;
      x_step_in   = x_step_ff;
      y_step_in   = y_step_ff;
      max_iter_in = max_iter_ff;
      if (csr_write) begin
         case (csr_index)
            mep_pkg::REG_X_MIN:    x_min_in    = csr_pwdata[W-1:0];
            mep_pkg::REG_Y_MIN:    y_min_in    = csr_pwdata[W-1:0];
            mep_pkg::REG_X_STEP:   x_step_in   = csr_pwdata[W-2:0];
            mep_pkg::REG_Y_STEP:   y_step_in   = csr_pwdata[W-2:0];
            mep_pkg::REG_MAX_ITER: max_iter_in = csr_pwdata[IW-1:0];
            default:               x_min_in    = x_min_ff;
         endcase
      end
   end

   // Read data follows the address.
   always_comb begin
      case (csr_index)
         mep_pkg::REG_X_MIN:    csr_prdata = CSR_DATA_WIDTH'(x_min_ff);
         mep_pkg::REG_Y_MIN:    csr_prdata = CSR_DATA_WIDTH'(y_min_ff);
         mep_pkg::REG_X_STEP:   csr_prdata = CSR_DATA_WIDTH'(x_step_ff);
         mep_pkg::REG_Y_STEP:   csr_prdata = CSR_DATA_WIDTH'(y_step_ff);
         mep_pkg::REG_MAX_ITER: csr_prdata = CSR_DATA_WIDTH'(max_iter_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= EDGE_RESET;
         y_min_ff    <= EDGE_RESET;
         x_step_ff   <= STEP_RESET;
         y_step_ff   <= STEP_RESET;
         max_iter_ff <= mep_pkg::MAX_ITER_RESET;
      end else begin
         x_min_ff    <= x_min_in;
         y_min_ff    <= y_min_in;
         x_step_ff   <= x_step_in;
         y_step_ff   <= y_step_in;
         max_iter_ff <= max_iter_in;
      end
   end

   // Front: maps pixel positions to points.
   mep_front #(
      .COORD_WIDTH (W),
      .POS_WIDTH   (POS_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_col   (req_tdata[POS_WIDTH-1:0]),
      .in_row   (req_tdata[2*POS_WIDTH-1:POS_WIDTH]),
      .x_min    (x_min_ff),
      .y_min    (y_min_ff),
      .x_step   (x_step_ff),
      .y_step   (y_step_ff),
      .q_status (q_status),
      .q_push   (q_push),
      .c_re     (f_c_re),
      .c_im     (f_c_im),
      .out_col  (f_col),
      .out_row  (f_row)
   );

   assign q_wdata = {f_row, f_col, f_c_im, f_c_re};

   mep_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   // Back: iteration engine, gray level and output register.
   mep_back #(
      .COORD_WIDTH (W),
      .FRAC_WIDTH  (FRAC_WIDTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_c_re         (q_rdata[W-1:0]),
      .q_c_im         (q_rdata[2*W-1:W]),
      .q_col          (q_rdata[2*W+POS_WIDTH-1:2*W]),
      .q_row          (q_rdata[QW-1:2*W+POS_WIDTH]),
      .q_pop          (q_pop),
      .max_iter       (max_iter_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_col        (rsp_col),
      .rsp_row        (rsp_row),
      .rsp_iterations (rsp_iterations),
      .rsp_gray       (rsp_gray)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'({rsp_gray, rsp_iterations, rsp_row, rsp_col});

   // The front never writes into a full queue.
   a_push_not_full: assert property (
      @(posedge clock) disable iff (reset) q_push |-> !q_status.full
   ) else $error("point queue written while full");

   // The engine never takes a point from an empty queue.
   a_pop_not_empty: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> !q_status.empty
   ) else $error("point queue read while empty");

   // Queue status flags never claim full and empty together.
   a_status_sane: assert property (
      @(posedge clock) disable iff (reset) !(q_status.full && q_status.empty)
   ) else $error("point queue status inconsistent");

endmodule

`default_nettype wire
